>>> rtl/sgr_pkg.sv
// sgr_pkg: shared types, constants and the 5x7 font tables for the glyph row generator.
// No dependencies; imported by every module under rtl.
package sgr_pkg;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int ROM_SIZE   = 90;
  localparam int MASK_W     = 40;
  localparam int CODE_W     = 8;
  localparam int COORD_W    = 13;
  localparam int ROW_Y_W    = 14;
  localparam int FRAME_W    = 13;
  localparam int SCALE_W    = 4;
  localparam int SHIFT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE   = 2'd0,
    REG_FRAME_W = 2'd1,
    REG_FRAME_H = 2'd2,
    REG_INK     = 2'd3
  } cfg_reg_e;

  typedef logic [6:0]            glyph_idx_t;
  typedef logic [GLYPH_COLS-1:0] glyph_row_t;
  typedef logic [2:0]            row_sel_t;

  // one character waiting for or under row generation
  typedef struct packed {
    glyph_idx_t                 glyph;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [MASK_W-1:0]          hclip;
  } item_t;

  // bit 4 of each row is the leftmost pixel
  localparam glyph_row_t FONT_ROM [ROM_SIZE][GLYPH_ROWS] = '{
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
    '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
    '{5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
    '{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
    '{5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
    '{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E},
    '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
    '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
    '{5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00},
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C},
    '{5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03},
    '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
    '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
    '{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
    '{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
    '{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
    '{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
    '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
    '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
    '{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E},
    '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    '{5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
    '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
    '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
    '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
    '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
    '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
    '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
    '{5'h11,5'h0A,5'h04,5'h04,5'h04,5'h0A,5'h11},
    '{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
    '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
    '{5'h00,5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08},
    '{5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00},
    '{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02},
    '{5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
    '{5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00},
    '{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
    '{5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E},
    '{5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E},
    '{5'h10,5'h08,5'h04,5'h02,5'h04,5'h08,5'h10},
    '{5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F},
    '{5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h1E},
    '{5'h00,5'h00,5'h0E,5'h10,5'h10,5'h11,5'h0E},
    '{5'h01,5'h01,5'h0D,5'h13,5'h11,5'h11,5'h0F},
    '{5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E},
    '{5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08},
    '{5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h0E},
    '{5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11},
    '{5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E},
    '{5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C},
    '{5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12},
    '{5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    '{5'h00,5'h00,5'h1A,5'h15,5'h15,5'h11,5'h11},
    '{5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11},
    '{5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E},
    '{5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10},
    '{5'h00,5'h00,5'h0D,5'h13,5'h0F,5'h01,5'h01},
    '{5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10},
    '{5'h00,5'h00,5'h0E,5'h10,5'h0E,5'h01,5'h1E},
    '{5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06},
    '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D},
    '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04},
    '{5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A},
    '{5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11},
    '{5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E},
    '{5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F},
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F},
    '{5'h00,5'h15,5'h0E,5'h1F,5'h0E,5'h15,5'h00},
    '{5'h0E,5'h11,5'h01,5'h06,5'h04,5'h00,5'h04},
    '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04},
    '{5'h0C,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00},
    '{5'h0A,5'h0A,5'h14,5'h00,5'h00,5'h00,5'h00},
    '{5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10},
    '{5'h10,5'h08,5'h08,5'h04,5'h02,5'h02,5'h01},
    '{5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02},
    '{5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h04,5'h08},
    '{5'h0E,5'h11,5'h15,5'h17,5'h10,5'h11,5'h0E},
    '{5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A},
    '{5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04},
    '{5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D},
    '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}
  };

  function automatic glyph_row_t font_row(glyph_idx_t g, row_sel_t r);
    glyph_row_t bits;
    bits = '0;
    if (int'(g) < ROM_SIZE && int'(r) < GLYPH_ROWS) begin
      bits = FONT_ROM[g][r];
    end
    return bits;
  endfunction

  // character code to glyph index, blank (0) for codes without a glyph
  function automatic glyph_idx_t glyph_index(logic [CODE_W-1:0] c);
    glyph_idx_t g;
    g = '0;
    if (c >= 8'd48 && c <= 8'd57) begin
      g = 7'(c - 8'd47);
    end else if (c >= 8'd65 && c <= 8'd69) begin
      g = 7'(c - 8'd47);
    end else if (c >= 8'd72 && c <= 8'd76) begin
      g = 7'(c - 8'd48);
    end else if (c >= 8'd84 && c <= 8'd90) begin
      g = 7'(c - 8'd51);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      g = 7'(c - 8'd48);
    end else begin
      case (c)
        8'd58:  g = 7'd11;
        8'd46:  g = 7'd12;
        8'd37:  g = 7'd13;
        8'd70:  g = 7'd14;
        8'd80:  g = 7'd15;
        8'd83:  g = 7'd16;
        8'd77:  g = 7'd17;
        8'd71:  g = 7'd23;
        8'd78:  g = 7'd29;
        8'd79:  g = 7'd30;
        8'd81:  g = 7'd31;
        8'd82:  g = 7'd32;
        8'd44:  g = 7'd40;
        8'd61:  g = 7'd41;
        8'd40:  g = 7'd42;
        8'd41:  g = 7'd43;
        8'd43:  g = 7'd44;
        8'd45:  g = 7'd45;
        8'd91:  g = 7'd46;
        8'd93:  g = 7'd47;
        8'd62:  g = 7'd48;
        8'd95:  g = 7'd75;
        8'd42:  g = 7'd76;
        8'd63:  g = 7'd77;
        8'd33:  g = 7'd78;
        8'd39:  g = 7'd79;
        8'd34:  g = 7'd80;
        8'd47:  g = 7'd81;
        8'd92:  g = 7'd82;
        8'd60:  g = 7'd83;
        8'd59:  g = 7'd84;
        8'd64:  g = 7'd85;
        8'd35:  g = 7'd86;
        8'd36:  g = 7'd87;
        8'd38:  g = 7'd88;
        8'd124: g = 7'd89;
        default: g = '0;
      endcase
    end
    return g;
  endfunction

endpackage

>>> rtl/sgr_fetch.sv
// sgr_fetch: input register stage; maps the code to a glyph and builds the column clip mask.
// Depends on sgr_pkg.
module sgr_fetch import sgr_pkg::*; #(
  parameter int GLYPH_COUNT = 90
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CODE_W-1:0]         char_code_i,
  input  logic signed [COORD_W-1:0] x_pos_i,
  input  logic signed [COORD_W-1:0] y_pos_i,
  input  logic [FRAME_W-1:0]        frame_width_i,
  output logic                      item_valid_o,
  input  logic                      item_take_i,
  output item_t                     item_o
);

  logic  item_valid_q, item_valid_d;
  item_t item_q, item_d;
  logic  accept;

  assign in_ready_o = !item_valid_q || item_take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [ROW_Y_W-1:0] px;
    item_d.glyph = glyph_index(char_code_i);
    if (int'(item_d.glyph) >= GLYPH_COUNT) begin
      item_d.glyph = '0;
    end
    item_d.x = x_pos_i;
    item_d.y = y_pos_i;
    // column i of the cell is visible when 0 <= x + i < frame width
    for (int i = 0; i < MASK_W; i++) begin
      px = {x_pos_i[COORD_W-1], x_pos_i} + ROW_Y_W'(i);
      item_d.hclip[i] = !px[ROW_Y_W-1] && (px[ROW_Y_W-2:0] < frame_width_i);
    end
  end

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (item_take_i) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/sgr_row_gen.sv
// sgr_row_gen: walks a glyph's scaled rows, one per cycle unless stalled, into the output register.
// Depends on sgr_pkg.
module sgr_row_gen import sgr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  output logic                      item_take_o,
  input  item_t                     item_i,
  input  logic [SCALE_W-1:0]        scale_i,
  input  logic [FRAME_W-1:0]        frame_height_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ROW_Y_W-1:0] row_y_o,
  output logic signed [COORD_W-1:0] row_x_o,
  output logic [MASK_W-1:0]         row_mask_o,
  output logic                      last_row_o
);

  logic                      busy_q, busy_d;
  item_t                     cur_q, cur_d;
  row_sel_t                  grow_q, grow_d;
  logic [SCALE_W-1:0]        sub_q, sub_d;
  logic signed [ROW_Y_W-1:0] py_q, py_d;

  logic                      out_valid_q;
  logic signed [ROW_Y_W-1:0] row_y_q;
  logic signed [COORD_W-1:0] row_x_q;
  logic [MASK_W-1:0]         row_mask_q, mask;
  logic                      last_row_q;

  logic       adv, last, sub_end, vis;
  glyph_row_t bits;
  logic [MASK_W-1:0] ones, glyph_mask;

  assign adv     = !out_valid_q || out_ready_i;
  assign sub_end = (sub_q == scale_i - SCALE_W'(1));
  assign last    = (grow_q == row_sel_t'(GLYPH_ROWS - 1)) && sub_end;
  assign item_take_o = item_valid_i && (!busy_q || (adv && last));

  // horizontal scaling: glyph column c covers mask bits [c*s, c*s+s)
  assign bits = font_row(cur_q.glyph, grow_q);
  assign ones = (MASK_W'(1) << scale_i) - MASK_W'(1);
  always_comb begin
    glyph_mask = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      if (bits[GLYPH_COLS-1-c]) begin
        glyph_mask = glyph_mask | (ones << (SHIFT_W'(c) * SHIFT_W'(scale_i)));
      end
    end
  end

  assign vis  = !py_q[ROW_Y_W-1] && ($unsigned(py_q) < {1'b0, frame_height_i});
  assign mask = vis ? (glyph_mask & cur_q.hclip) : '0;

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    grow_d = grow_q;
    sub_d  = sub_q;
    py_d   = py_q;
    if (busy_q && adv) begin
      py_d = py_q + ROW_Y_W'(1);
      if (sub_end) begin
        sub_d  = '0;
        grow_d = grow_q + row_sel_t'(1);
      end else begin
        sub_d = sub_q + SCALE_W'(1);
      end
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (item_take_o) begin
      busy_d = 1'b1;
      cur_d  = item_i;
      grow_d = '0;
      sub_d  = '0;
      py_d   = {item_i.y[COORD_W-1], item_i.y};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      grow_q      <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      grow_q <= grow_d;
      sub_q  <= sub_d;
      if (adv) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    py_q  <= py_d;
    if (adv && busy_q) begin
      row_y_q    <= py_q;
      row_x_q    <= cur_q.x;
      row_mask_q <= mask;
      last_row_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_y_o     = row_y_q;
  assign row_x_o     = row_x_q;
  assign row_mask_o  = row_mask_q;
  assign last_row_o  = last_row_q;

endmodule

>>> rtl/scaled_glyph_row_generator.sv
// Each character word (code, cell x, cell y) is drawn from a fixed 5x7 font as 7*s rows,
// s the effective scale (0 reads as 1, values above MAX_SCALE saturate). The row generator
// emits one scaled row per cycle while the output is not stalled; the next character waits
// in the input register and its first row follows the previous last row directly.
// A character passes the input register and the row generator into the output register.
// Rows and columns outside the frame are cleared from the mask, rows are still sent.
// The ink color register is accepted on the write port but has no effect on the rows.
// Depends on sgr_pkg, sgr_fetch and sgr_row_gen.
module scaled_glyph_row_generator import sgr_pkg::*; #(
  parameter int GLYPH_COUNT = 90,
  parameter int MAX_SCALE   = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CODE_W-1:0]         char_code_i,
  input  logic signed [COORD_W-1:0] x_pos_i,
  input  logic signed [COORD_W-1:0] y_pos_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ROW_Y_W-1:0] row_y_o,
  output logic signed [COORD_W-1:0] row_x_o,
  output logic [MASK_W-1:0]         row_mask_o,
  output logic                      last_row_o
);

  logic [SCALE_W-1:0] scale_q;
  logic [FRAME_W-1:0] frame_w_q, frame_h_q;
  logic [SCALE_W-1:0] s_eff;
  logic               item_valid, item_take;
  item_t              item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_W'(1);
      frame_w_q <= FRAME_W'(640);
      frame_h_q <= FRAME_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SCALE:   scale_q   <= cfg_wdata_i[SCALE_W-1:0];
        REG_FRAME_W: frame_w_q <= cfg_wdata_i[FRAME_W-1:0];
        REG_FRAME_H: frame_h_q <= cfg_wdata_i[FRAME_W-1:0];
        REG_INK:     ;
        default:     ;
      endcase
    end
  end

  always_comb begin
    if (scale_q == '0) begin
      s_eff = SCALE_W'(1);
    end else if (int'(scale_q) > MAX_SCALE) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_q;
    end
  end

  sgr_fetch #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_fetch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .frame_width_i (frame_w_q),
    .item_valid_o  (item_valid),
    .item_take_i   (item_take),
    .item_o        (item)
  );

  sgr_row_gen u_row_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_take_o    (item_take),
    .item_i         (item),
    .scale_i        (s_eff),
    .frame_height_i (frame_h_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_y_o        (row_y_o),
    .row_x_o        (row_x_o),
    .row_mask_o     (row_mask_o),
    .last_row_o     (last_row_o)
  );

`ifndef SYNTH
  // rows of one glyph follow each other without a gap and step down one frame row
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      out_valid_o && (row_y_o == $past(row_y_o) + ROW_Y_W'(1)))
    else $error("glyph rows not contiguous");

  // no pixel beyond the scaled cell width
  a_mask_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((row_mask_o >> (SHIFT_W'(GLYPH_COLS) * SHIFT_W'(s_eff))) == '0))
    else $error("mask bit beyond scaled glyph width");

  // a row word stays with the same column origin within one glyph
  a_row_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=> row_x_o == $past(row_x_o))
    else $error("row x changed inside a glyph");
`endif

endmodule
